[rtl/job_dispatcher_defines.svh]
// ---------------------------------------------------------------------------
// Job dispatcher assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef JOB_DISPATCHER_DEFINES_SVH
`define JOB_DISPATCHER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define JD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle that implies a consequence in the next.
`define JD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define JD_ASSERT(lbl, prop, msg)
`define JD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/jd_pkg.sv]
// ---------------------------------------------------------------------------
// Job dispatcher package
// Field widths, command and status codes, and the control structs shared
// between the dispatcher and its worker allocator.
// ---------------------------------------------------------------------------
package jd_pkg;

  // Fixed port widths.
  localparam int JOB_W = 32;
  localparam int WID_W = 3;
  localparam int QC_W  = 11;
  localparam int ACT_W = 4;

  // Default sizing.
  localparam int DEF_WORKERS     = 8;
  localparam int DEF_QUEUE_DEPTH = 1024;
  localparam int DEF_JOB_BITS    = 32;

  // Configuration.
  localparam logic [ACT_W-1:0] ACT_RESET      = 4'd8;
  localparam logic             REG_IDX_ACTIVE = 1'b0;

  // Input commands.
  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_DONE   = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ASSIGNED = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_REFILLED = 3'd3,
    ST_IDLE     = 3'd4,
    ST_BAD_DONE = 3'd5
  } status_t;

  // Requests from the dispatcher to the allocator.
  typedef struct packed {
    logic claim;   // mark the lowest idle enabled worker busy
    logic retire;  // mark the finishing worker idle
  } alloc_ctl_t;

  // Answers from the allocator.
  typedef struct packed {
    logic free_found;  // some enabled worker is idle
    logic done_ok;     // the finishing worker is enabled and busy
  } alloc_stat_t;

endpackage

[rtl/jd_ram.sv]
// ---------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered and holds its
// value between reads.
// ---------------------------------------------------------------------------
module jd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/jd_alloc.sv]
// ---------------------------------------------------------------------------
// Job dispatcher worker allocator
// Holds the busy bits, finds the lowest idle enabled worker and checks done
// reports against the enabled, busy set.
// ---------------------------------------------------------------------------
`include "job_dispatcher_defines.svh"

module jd_alloc #(
  parameter int WORKERS = 8,
  parameter int IDX_W   = (WORKERS > 1) ? $clog2(WORKERS) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [jd_pkg::ACT_W-1:0] act_cnt,
  input  logic [jd_pkg::WID_W-1:0] done_id,
  input  jd_pkg::alloc_ctl_t       ctl,
  output jd_pkg::alloc_stat_t      stat,
  output logic [IDX_W-1:0]         free_idx,
  output logic                     idle_after
);

  import jd_pkg::*;

  logic [WORKERS-1:0] busy;
  logic [WORKERS-1:0] busy_next;
  logic [WORKERS-1:0] en;

  // Workers below the active count are enabled.
  always_comb begin
    for (int i = 0; i < WORKERS; i++) begin
      en[i] = (i < int'(act_cnt));
    end
  end

  // Priority search for the lowest idle enabled worker, and done check.
  always_comb begin
    stat.free_found = 1'b0;
    stat.done_ok    = 1'b0;
    free_idx        = '0;
    for (int i = WORKERS - 1; i >= 0; i--) begin
      if (en[i] && !busy[i]) begin
        stat.free_found = 1'b1;
        free_idx        = IDX_W'(i);
      end
    end
    for (int i = 0; i < WORKERS; i++) begin
      if ((i == int'(done_id)) && en[i] && busy[i]) begin
        stat.done_ok = 1'b1;
      end
    end
  end

  // Busy bits after this step; disabled workers keep theirs.
  always_comb begin
    for (int i = 0; i < WORKERS; i++) begin
      busy_next[i] = (busy[i] || (ctl.claim && (i == int'(free_idx))))
                     && !(ctl.retire && (i == int'(done_id)));
    end
    idle_after = ((busy_next & en) == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      busy <= busy_next;
    end
  end

  `JD_ASSERT(a_free_is_idle, stat.free_found |-> (en[free_idx] && !busy[free_idx]),
             "allocator picked a busy or disabled worker")
  `JD_ASSERT_NEXT(a_claim_sets, ctl.claim, busy[$past(free_idx)],
                  "claimed worker not marked busy")
  `JD_ASSERT(a_one_op, !(ctl.claim && ctl.retire), "claim and retire in the same step")

endmodule

[rtl/job_dispatcher.sv]
// ---------------------------------------------------------------------------
// Job dispatcher
// Hands submitted jobs to the lowest idle enabled worker, queues the rest in
// a ring FIFO, and refills finishing workers from that FIFO.
// ---------------------------------------------------------------------------
// The block takes one item per clock cycle when the result side keeps up.
// Each result passes through a result stage, where a refill waits for the
// registered read of the FIFO memory, then the output register. The single
// FIFO memory sees at most one access per item (a write for a queued job, a
// read for a refill), and all bookkeeping is updated at the transfer, so
// back-to-back items need no forwarding. The FIFO memory needs no clearing
// after reset; entries are only read after being written. Write
// active_workers only while the block is idle.
`include "job_dispatcher_defines.svh"

module job_dispatcher #(
  parameter int WORKERS     = jd_pkg::DEF_WORKERS,
  parameter int QUEUE_DEPTH = jd_pkg::DEF_QUEUE_DEPTH,
  parameter int JOB_BITS    = jd_pkg::DEF_JOB_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic [jd_pkg::JOB_W-1:0] job_word,
  input  logic [jd_pkg::WID_W-1:0] worker_id,
  // Output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               status,
  output logic [jd_pkg::WID_W-1:0] assigned_worker,
  output logic [jd_pkg::JOB_W-1:0] assigned_job,
  output logic [jd_pkg::QC_W-1:0]  queue_count,
  output logic                     all_idle
);

  import jd_pkg::*;

  localparam int IDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SB    = (JOB_BITS < JOB_W) ? JOB_BITS : JOB_W;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Configuration register.
  logic [ACT_W-1:0] active_workers;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_ACTIVE);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= ACT_RESET;
    end else if (cfg_wr) begin
      active_workers <= pwdata[ACT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX_ACTIVE) begin
      prdata = 32'(active_workers);
    end
  end

  // FIFO bookkeeping.
  logic [PTR_W-1:0] wp, wp_next;
  logic [PTR_W-1:0] rp, rp_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             ram_we, ram_re;
  logic [SB-1:0]    ram_rdata;
  logic [SB-1:0]    in_job;

  // Allocator interface.
  alloc_ctl_t       ctl;
  alloc_stat_t      stat;
  logic [IDX_W-1:0] free_idx;
  logic             idle_after;

  // Result stage and output register.
  logic             pend_valid;
  logic             pend_move;
  status_t          pend_status;
  logic [WID_W-1:0] pend_worker;
  logic [SB-1:0]    pend_job;
  logic             pend_from_ram;
  logic [CNT_W-1:0] pend_count;
  logic             pend_idle;

  status_t          nx_status;
  logic [WID_W-1:0] nx_worker;
  logic [SB-1:0]    nx_job;
  logic             nx_from_ram;

  status_t          out_status;
  logic [WID_W-1:0] out_worker;
  logic [SB-1:0]    out_job;
  logic [CNT_W-1:0] out_count;
  logic             out_idle;

  logic in_acc;

  assign in_job    = SB'(job_word);
  assign pend_move = pend_valid && (!out_valid || !out_stall);
  assign in_stall  = pend_valid && !pend_move;
  assign in_acc    = in_valid && !in_stall;

  jd_alloc #(
    .WORKERS (WORKERS),
    .IDX_W   (IDX_W)
  ) u_alloc (
    .clk        (clk),
    .rst        (rst),
    .act_cnt    (active_workers),
    .done_id    (worker_id),
    .ctl        (ctl),
    .stat       (stat),
    .free_idx   (free_idx),
    .idle_after (idle_after)
  );

  jd_ram #(
    .WIDTH (SB),
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (in_job),
    .re    (ram_re),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  // Per-item decision: assign, queue, drop, refill, release or reject.
  always_comb begin
    ctl         = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    wp_next     = wp;
    rp_next     = rp;
    cnt_next    = cnt;
    nx_status   = ST_BAD_DONE;
    nx_worker   = '0;
    nx_job      = '0;
    nx_from_ram = 1'b0;
    if (in_acc) begin
      if (cmd == CMD_SUBMIT) begin
        if (stat.free_found) begin
          ctl.claim = 1'b1;
          nx_status = ST_ASSIGNED;
          nx_worker = WID_W'(free_idx);
          nx_job    = in_job;
        end else if (cnt == CNT_W'(QUEUE_DEPTH)) begin
          nx_status = ST_DROPPED;
        end else begin
          ram_we    = 1'b1;
          wp_next   = ptr_inc(wp);
          cnt_next  = cnt + CNT_W'(1);
          nx_status = ST_QUEUED;
        end
      end else begin
        if (!stat.done_ok) begin
          nx_status = ST_BAD_DONE;
        end else if (cnt != '0) begin
          ram_re      = 1'b1;
          rp_next     = ptr_inc(rp);
          cnt_next    = cnt - CNT_W'(1);
          nx_status   = ST_REFILLED;
          nx_worker   = worker_id;
          nx_from_ram = 1'b1;
        end else begin
          ctl.retire = 1'b1;
          nx_status  = ST_IDLE;
        end
      end
    end
  end

  // Pointer and count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp_next;
      rp  <= rp_next;
      cnt <= cnt_next;
    end
  end

  // Result stage; a refill waits here for the registered memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_acc) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_status   <= nx_status;
      pend_worker   <= nx_worker;
      pend_job      <= nx_job;
      pend_from_ram <= nx_from_ram;
      pend_count    <= cnt_next;
      pend_idle     <= idle_after;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_status <= pend_status;
      out_worker <= pend_worker;
      out_job    <= pend_from_ram ? ram_rdata : pend_job;
      out_count  <= pend_count;
      out_idle   <= pend_idle;
    end
  end

  assign status          = out_status;
  assign assigned_worker = out_worker;
  assign assigned_job    = JOB_W'(out_job);
  assign queue_count     = QC_W'(out_count);
  assign all_idle        = out_idle;

  `JD_ASSERT(a_cnt_range, cnt <= CNT_W'(QUEUE_DEPTH), "FIFO count above depth")
  `JD_ASSERT(a_drop_full,
             (pend_valid && (pend_status == ST_DROPPED)) |-> (pend_count == CNT_W'(QUEUE_DEPTH)),
             "job dropped while FIFO not full")
  `JD_ASSERT_NEXT(a_pop_count, in_acc && ram_re, cnt == $past(cnt) - CNT_W'(1),
                  "refill did not pop one entry")
  `JD_ASSERT_NEXT(a_move_out, pend_move, out_valid, "result lost between stage and output")

endmodule
